// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define PRM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PRM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hw/rtl/prm_pkg.sv -----
// Package: widths, constants, codes and controller/datapath interface types.
`default_nettype none

package prm_pkg;

   localparam int TicksW   = 16;
   localparam int TickTimeW = 8;
   localparam int RevW     = TicksW + TickTimeW + 1;   // 2 * mid * tick
   localparam int DivBits  = 20;                       // bits of one million
   localparam int BitCntW  = $clog2(DivBits);
   localparam int RpsW     = 16;
   localparam int RpmW     = 16;
   localparam int MinuteW  = 6;
   localparam int RpmProdW = RpsW + MinuteW;

   localparam logic [DivBits-1:0]   US_PER_SECOND      = DivBits'(1000000);
   localparam logic [MinuteW-1:0]   SECONDS_PER_MINUTE = MinuteW'(60);
   localparam logic [TicksW-1:0]    SHORTEST_RESET     = {TicksW{1'b1}};
   localparam logic [TicksW-1:0]    LONGEST_RESET      = '0;
   localparam logic [TickTimeW-1:0] TICK_TIME_RESET    = TickTimeW'(23);

   localparam logic OP_PULSE  = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   typedef struct packed {
      logic load_pulse;    // fold a new interval into longest/shortest
      logic load_report;   // capture midpoint and clear tracking
      logic mul;           // form the revolution time, start the divider
      logic div_step;      // one quotient bit
      logic finish;        // scale to rpm and load the result register
   } cmd_type;

   typedef struct packed {
      logic meas_ok;       // valid measurement with a nonzero revolution time
      logic div_last;      // divider on its final bit
      logic out_free;      // result register can take a word this cycle
   } status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/pulse_interval_rpm_meter_core.sv -----
// Top level: fan tachometer turning pulse intervals into RPM reports.
//
//   channel   direction  tdata               tuser
//   req_      in         interval_ticks[15:0] opcode (0 pulse, 1 report)
//   rsp_      out        rpm[15:0]            no_measurement
//   csr_      in         tick_time_us[7:0]    -
//
// A pulse word is taken without a stall; req_tready stays high across a run of pulses.
// A report word runs through capture, multiply, the bit-serial restoring divider
// and result load; with no measurement the divider takes no steps.
// The result register holds one word, so a report waits in its last cycle
// only while the previous result is still unread.
// Synchronous reset sets tick time to 23 and clears min/max tracking.
`default_nettype none

`include "assert_macros.svh"

module pulse_interval_rpm_meter_core
   import prm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [15:0]          req_tdata,    // [15:0] interval_ticks
   input  wire logic                 req_tuser,    // [0] opcode
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [15:0]               rsp_tdata,    // [15:0] rpm
   output logic                      rsp_tuser,    // [0] no_measurement
   input  wire logic                 csr_wr_en,
   input  wire logic [TickTimeW-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   prm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   prm_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_ticks   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_rpm     (rsp_tdata),
      .rsp_none    (rsp_tuser)
   );

   `PRM_ASSERT(a_none_zero, rsp_tvalid && rsp_tuser |-> rsp_tdata == '0, "flagged word with nonzero rpm")
   `PRM_ASSERT(a_report_busy, req_tvalid && req_tready && req_tuser == OP_REPORT |=> !req_tready, "ready right after report")
   `PRM_ASSERT(a_pulse_quick, req_tvalid && req_tready && req_tuser == OP_PULSE |=> req_tready, "pulse word stalled input")
   `PRM_ASSERT_ALWAYS(a_reset_empty, $past(reset) === 1'b1 |-> !rsp_tvalid, "result valid after reset")

endmodule

`default_nettype wire

// ----- hw/rtl/prm_ctrl.sv -----
// Controller: sequences a report through multiply, divide and result load.
`default_nettype none

module prm_ctrl
   import prm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tuser,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_REPORT) begin
                  cmd.load_report = 1'b1;
                  state_in        = ST_MULT;
               end else begin
                  cmd.load_pulse = 1'b1;
               end
            end
         end
         ST_MULT: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // skip the divider when there is nothing to divide by
            if (!status.meas_ok) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_step = 1'b1;
               if (status.div_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/prm_dp.sv -----
// Datapath: interval tracking, revolution time, restoring divider, result register.
`default_nettype none

module prm_dp
   import prm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [TicksW-1:0]    req_ticks,
   input  wire logic                 csr_wr_en,
   input  wire logic [TickTimeW-1:0] csr_wr_data,
   input  wire cmd_type              cmd,
   output status_type                status,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RpmW-1:0]           rsp_rpm,
   output logic                      rsp_none
);

   logic [TickTimeW-1:0] tick_ff;
   logic [TicksW-1:0]    longest_ff, shortest_ff;
   logic [TicksW-1:0]    mid_ff;
   logic                 meas_ff;
   logic [RevW-1:0]      rev_ff;
   logic [RevW-1:0]      rem_ff;
   logic [DivBits-1:0]   quot_ff;
   logic [BitCntW-1:0]   bit_ff;
   logic                 out_valid_ff;
   logic [RpmW-1:0]      rpm_ff;
   logic                 none_ff;

   logic [TicksW:0]                sum;
   logic [TicksW+TickTimeW-1:0]    rev_prod;
   logic [RevW:0]                  trial;
   logic                           fits;
   logic [RpmProdW-1:0]            rpm_prod;

   assign sum      = {1'b0, longest_ff} + {1'b0, shortest_ff};
   assign rev_prod = (TicksW+TickTimeW)'(mid_ff) * (TicksW+TickTimeW)'(tick_ff);
   // bring down the next dividend bit
   assign trial    = {rem_ff, US_PER_SECOND[bit_ff]};
   assign fits     = trial >= {1'b0, rev_ff};
   assign rpm_prod = RpmProdW'(quot_ff[RpsW-1:0]) * RpmProdW'(SECONDS_PER_MINUTE);

   assign status.meas_ok  = meas_ff && (rev_ff != '0);
   assign status.div_last = (bit_ff == '0);
   assign status.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_rpm    = rpm_ff;
   assign rsp_none   = none_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= TICK_TIME_RESET;
         longest_ff  <= LONGEST_RESET;
         shortest_ff <= SHORTEST_RESET;
      end else begin
         if (csr_wr_en) begin
            tick_ff <= csr_wr_data;
         end
         if (cmd.load_pulse) begin
            if (req_ticks > longest_ff) begin
               longest_ff <= req_ticks;
            end
            if (req_ticks < shortest_ff) begin
               shortest_ff <= req_ticks;
            end
         end else if (cmd.load_report) begin
            longest_ff  <= LONGEST_RESET;
            shortest_ff <= SHORTEST_RESET;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_report) begin
         mid_ff  <= sum[TicksW:1];
         meas_ff <= (longest_ff >= shortest_ff);
      end
      if (cmd.mul) begin
         rev_ff  <= {rev_prod, 1'b0};
         rem_ff  <= '0;
         quot_ff <= '0;
         bit_ff  <= BitCntW'(DivBits - 1);
      end else if (cmd.div_step) begin
         if (fits) begin
            rem_ff <= RevW'(trial - {1'b0, rev_ff});
         end else begin
            rem_ff <= trial[RevW-1:0];
         end
         quot_ff <= {quot_ff[DivBits-2:0], fits};
         bit_ff  <= bit_ff - BitCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rpm_ff  <= status.meas_ok ? rpm_prod[RpmW-1:0] : '0;
         none_ff <= !status.meas_ok;
      end
   end

endmodule

`default_nettype wire

// ----- bench/pulse_interval_rpm_meter_checker.sv -----
// Scoreboard for the RPM meter: predicts each report word and checks the result stream.
`timescale 1ns / 1ps

module pulse_interval_rpm_meter_checker
   import prm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tready,
   input  wire logic [15:0]          req_tdata,    // [15:0] interval_ticks
   input  wire logic                 req_tuser,    // [0] opcode
   input  wire logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic [15:0]          rsp_tdata,    // [15:0] rpm
   input  wire logic                 rsp_tuser,    // [0] no_measurement
   input  wire logic                 csr_wr_en,
   input  wire logic [TickTimeW-1:0] csr_wr_data,
   output int                        err_count,
   output int                        pending,
   output int                        reports_seen,
   output int                        empty_reports
);

   localparam int MAX_SHOWN = 10;
   localparam logic [1:0] PULSES_PER_REV = 2'd2;

   typedef struct packed {
      logic [15:0] rpm;
      logic        none;
   } rpm_word_type;

   rpm_word_type         rpm_due[$];
   logic [TicksW-1:0]    longest_ticks;
   logic [TicksW-1:0]    shortest_ticks;
   logic [TickTimeW-1:0] tick_us;
   int                   errors;
   int                   reports;
   int                   empties;

   initial begin
      err_count = 0;
      pending = 0;
      reports_seen = 0;
      empty_reports = 0;
      errors = 0;
      reports = 0;
      empties = 0;
      longest_ticks = LONGEST_RESET;
      shortest_ticks = SHORTEST_RESET;
      tick_us = TICK_TIME_RESET;
   end

   function automatic rpm_word_type predict_rpm(input logic [TicksW-1:0] hi,
                                                input logic [TicksW-1:0] lo,
                                                input logic [TickTimeW-1:0] tick);
      rpm_word_type r;
      logic [16:0]  span_sum;
      logic [15:0]  mid;
      logic [31:0]  rev_us;
      logic [31:0]  rps_full;
      logic [15:0]  rps;
      logic [21:0]  prod;
      r.rpm = '0;
      r.none = 1'b1;
      // min above max means no pulse since the last report
      if (hi >= lo) begin
         span_sum = {1'b0, hi} + {1'b0, lo};
         mid = span_sum[16:1];
         rev_us = 32'(mid) * 32'(tick) * 32'(PULSES_PER_REV);
         if (rev_us != 32'd0) begin
            rps_full = 32'(US_PER_SECOND) / rev_us;
            rps = rps_full[15:0];
            prod = 22'(rps) * 22'(SECONDS_PER_MINUTE);
            r.rpm = prod[15:0];
            r.none = 1'b0;
         end
      end
      return r;
   endfunction

   task automatic note_error(input string what, input rpm_word_type want);
      errors++;
      if (errors <= MAX_SHOWN)
         $display("%0t %s: expected rpm=%0d none=%0b, got rpm=%0d none=%0b",
                  $realtime, what, want.rpm, want.none, rsp_tdata, rsp_tuser);
   endtask

   always @(posedge clock) begin : watch
      rpm_word_type want;
      if (reset) begin
         rpm_due.delete();
         longest_ticks = LONGEST_RESET;
         shortest_ticks = SHORTEST_RESET;
         tick_us = TICK_TIME_RESET;
      end else begin
         if (csr_wr_en)
            tick_us = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (rpm_due.size() == 0) begin
               want = '0;
               note_error("unexpected word", want);
            end else begin
               want = rpm_due.pop_front();
               if (want.rpm !== rsp_tdata || want.none !== rsp_tuser)
                  note_error("mismatch", want);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_PULSE) begin
               if (req_tdata > longest_ticks)
                  longest_ticks = req_tdata;
               if (req_tdata < shortest_ticks)
                  shortest_ticks = req_tdata;
            end else begin
               want = predict_rpm(longest_ticks, shortest_ticks, tick_us);
               rpm_due.push_back(want);
               reports++;
               if (want.none)
                  empties++;
               // clear tracking after every report, empty ones too
               longest_ticks = LONGEST_RESET;
               shortest_ticks = SHORTEST_RESET;
            end
         end
      end
      err_count <= errors;
      pending <= rpm_due.size();
      reports_seen <= reports;
      empty_reports <= empties;
   end

endmodule

// ----- bench/tb.sv -----
// Testbench top: drives pulse and report words into the RPM meter and gives the verdict.
`timescale 1ns / 1ps

module tb;
   import prm_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 40;
   localparam int QUIET_LIMIT  = 5000;
   localparam int SEG_ITEMS    = 87;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata = '0;
   logic                 req_tuser = OP_PULSE;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_wr_en = 1'b0;
   logic [TickTimeW-1:0] csr_wr_data = '0;

   int err_count;
   int pending;
   int reports_seen;
   int empty_reports;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int pulses_sent = 0;
   int tick_settings = 1;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   pulse_interval_rpm_meter_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pulse_interval_rpm_meter_checker rpm_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .err_count     (err_count),
      .pending       (pending),
      .reports_seen  (reports_seen),
      .empty_reports (empty_reports)
   );

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // end the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
         $display("pulse_interval_rpm_meter_core regression: fail");
         $finish;
      end
   end

   function automatic logic [15:0] pick_ticks();
      case ($urandom_range(3))
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(3));
         2:       return 16'(16'hFFFF - $urandom_range(3));
         default: return 16'($urandom_range(5000, 20));
      endcase
   endfunction

   task automatic send_word(input logic op, input logic [15:0] ticks);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= ticks;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (op == OP_PULSE)
         pulses_sent++;
   endtask

   // hold until every report is answered, then let the block settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_tick(input logic [TickTimeW-1:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tick_settings++;
   endtask

   initial begin
      int seg;
      int sent;
      int burst;
      logic [TickTimeW-1:0] seg_tick;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at the reset tick time
      send_word(OP_REPORT, 16'h0000);          // no pulse yet
      send_word(OP_REPORT, 16'hFFFF);          // ticks field ignored on a report
      send_word(OP_PULSE, 16'h0000);
      send_word(OP_REPORT, 16'h0000);          // zero midpoint
      send_word(OP_PULSE, 16'hFFFF);
      send_word(OP_REPORT, 16'h5A5A);          // longest interval only
      send_word(OP_PULSE, 16'h0000);
      send_word(OP_PULSE, 16'hFFFF);
      send_word(OP_REPORT, 16'h0000);          // widest spread
      send_word(OP_PULSE, 16'h0001);
      send_word(OP_REPORT, 16'h0000);          // rpm wraps past 16 bits
      send_word(OP_PULSE, 16'd300);
      send_word(OP_PULSE, 16'd100);
      send_word(OP_PULSE, 16'd200);
      send_word(OP_REPORT, 16'h0000);

      write_tick(8'd255);
      send_word(OP_PULSE, 16'hFFFF);
      send_word(OP_REPORT, 16'h0000);
      write_tick(8'd1);
      send_word(OP_PULSE, 16'h0001);
      send_word(OP_REPORT, 16'h0000);          // shortest revolution time
      write_tick(8'd0);
      send_word(OP_PULSE, 16'd100);
      send_word(OP_REPORT, 16'h0000);          // zero tick time

      // random bursts of pulses closed by a report, under three idle mixes
      for (seg = 0; seg < 6; seg++) begin
         send_idle_pct = (seg < 2) ? 19 : (seg < 4) ? 62 : 0;
         recv_idle_pct = (seg < 2) ? 62 : (seg < 4) ? 19 : 0;
         case (seg)
            0:       seg_tick = 8'd255;
            2:       seg_tick = 8'd1;
            4:       seg_tick = TICK_TIME_RESET;
            default: seg_tick = 8'($urandom_range(254, 2));
         endcase
         write_tick(seg_tick);
         sent = 0;
         while (sent < SEG_ITEMS) begin
            if ($urandom_range(9) == 0) begin
               send_word(OP_REPORT, 16'($urandom));
               sent++;
            end else begin
               burst = $urandom_range(8, 1);
               repeat (burst) send_word(OP_PULSE, pick_ticks());
               send_word(OP_REPORT, 16'($urandom));
               sent += burst + 1;
            end
         end
      end

      wait_idle();
      $display("covered %0d pulse words and %0d reports (%0d without a measurement)",
               pulses_sent, reports_seen, empty_reports);
      $display("across %0d tick time settings; %0d errors", tick_settings, err_count);
      if (err_count == 0 && pending == 0)
         $display("pulse_interval_rpm_meter_core regression: pass");
      else
         $display("pulse_interval_rpm_meter_core regression: fail");
      $finish;
   end

endmodule
